>>> rtl/fci_pkg.sv
// ----------------------------------------------------------------------------
// Fan curve interpolator package
// Shared constants, types and a helper function for the fan curve blocks.
// ----------------------------------------------------------------------------
package fci_pkg;

    // Curve and sample format.
    localparam int CURVE_POINTS       = 9;
    localparam int MAX_POINTS         = 9;
    localparam int TEMP_FRACTION_BITS = 4;
    localparam int TEMP_W             = 13;
    localparam int PT_W               = 8;
    localparam int PCT_W              = 7;
    localparam int DUTY_W             = 8;
    localparam int SEG_W              = 4;
    localparam int PCT_MAX            = 100;

    // Configuration port.
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int LOW_W     = 40;
    localparam int HIGH_W    = 32;

    // Arithmetic widths of the interpolation path.
    localparam int DEN_W = PT_W + TEMP_FRACTION_BITS;
    localparam int V_W   = DEN_W + PT_W;
    localparam int DIFF_W = PT_W + 1;
    localparam int P1_W  = PT_W + DEN_W;
    localparam int P2_W  = DEN_W + 1 + DIFF_W;
    localparam int QUO_W = PT_W;
    localparam int THR_W = PT_W + TEMP_FRACTION_BITS + 1;
    localparam int CMP_W = ((THR_W > TEMP_W) ? THR_W : TEMP_W) + 1;

    // Duty = pct*255/100 done as pct * (255*5243) >> 19, exact for pct <= 100.
    localparam int PWM_MUL   = 1336965;
    localparam int PWM_SHIFT = 19;
    localparam int PROD_W    = 28;

    // Job queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMPS_LOW  = 2'd0,
        REG_TEMPS_HIGH = 2'd1,
        REG_PCTS_LOW   = 2'd2,
        REG_PCTS_HIGH  = 2'd3
    } t_reg_idx;

    // One classified item, as handed from the front to the back part.
    typedef struct packed {
        logic                     interp;
        logic [PCT_W-1:0]         pct;
        logic [SEG_W-1:0]         seg;
        logic [PT_W-1:0]          prev_p;
        logic signed [DIFF_W-1:0] diff;
        logic [DEN_W-1:0]         num;
        logic [DEN_W-1:0]         den;
    } t_job;

    // Queue status seen by the back part.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Saturate a percentage to 100.
    function automatic logic [PCT_W-1:0] sat100(input logic [PT_W-1:0] v);
        logic [PCT_W-1:0] r;
        if (v > PT_W'(PCT_MAX)) begin
            r = PCT_W'(PCT_MAX);
        end else begin
            r = v[PCT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/fan_curve_interpolator.sv
// An accepted item passes two product/sum stages, eight division stages and
// the output register. Throughput: one item per cycle while the output is
// not stalled; the one-bit-per-stage divider is pipelined.
// Reset: synchronous, active low; clears the queue, all valid bits and the
// curve registers to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Fan curve interpolator
// Maps a temperature sample to a fan percentage and PWM duty through a
// configured piecewise linear curve.
// ----------------------------------------------------------------------------
module fan_curve_interpolator
    import fci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [TEMP_W-1:0]  i_temperature,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [PCT_W-1:0]          o_fan_percent,
    output logic [DUTY_W-1:0]         o_pwm_duty,
    output logic [SEG_W-1:0]          o_segment
);

    t_job   front_job;
    t_job   head_job;
    t_qstat qstat;
    logic   pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = qstat.full;

    // Classification of each accepted item.
    fci_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_temperature (i_temperature),
        .o_job         (front_job)
    );

    // Queue between classification and arithmetic.
    fci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    // Arithmetic pipeline and output register.
    fci_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_fan_percent (o_fan_percent),
        .o_pwm_duty    (o_pwm_duty),
        .o_segment     (o_segment)
    );

endmodule

>>> rtl/fci_front.sv
// ----------------------------------------------------------------------------
// Fan curve front end
// Holds the curve registers, compares an item against every curve point and
// classifies it into a direct result or an interpolation job.
// ----------------------------------------------------------------------------
module fci_front
    import fci_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic signed [TEMP_W-1:0]    i_temperature,
    output t_job                        o_job
);

    logic [LOW_W-1:0]  r_temps_low;
    logic [HIGH_W-1:0] r_temps_high;
    logic [LOW_W-1:0]  r_pcts_low;
    logic [HIGH_W-1:0] r_pcts_high;

    logic [LOW_W+HIGH_W-1:0] temps_all;
    logic [LOW_W+HIGH_W-1:0] pcts_all;
    logic [PT_W-1:0]         pt_t [MAX_POINTS];
    logic [PT_W-1:0]         pt_p [MAX_POINTS];
    logic [CURVE_POINTS-1:0] hit;
    logic [CMP_W-1:0]        sample_ext;

    logic                    found;
    logic                    first;
    logic [SEG_W-1:0]        sel;
    logic [PT_W-1:0]         cur_t;
    logic [PT_W-1:0]         cur_p;
    logic [PT_W-1:0]         prev_t;
    logic [PT_W-1:0]         prev_p;
    logic [CMP_W-1:0]        num_full;
    logic [PT_W-1:0]         t_span;

    // Curve register writes; the port is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temps_low  <= '0;
            r_temps_high <= '0;
            r_pcts_low   <= '0;
            r_pcts_high  <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TEMPS_LOW:  r_temps_low  <= i_cfg_data[LOW_W-1:0];
                REG_TEMPS_HIGH: r_temps_high <= i_cfg_data[HIGH_W-1:0];
                REG_PCTS_LOW:   r_pcts_low   <= i_cfg_data[LOW_W-1:0];
                REG_PCTS_HIGH:  r_pcts_high  <= i_cfg_data[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the points and compare the sample against each threshold.
    assign temps_all  = {r_temps_high, r_temps_low};
    assign pcts_all   = {r_pcts_high, r_pcts_low};
    assign sample_ext = {{(CMP_W-TEMP_W){i_temperature[TEMP_W-1]}}, i_temperature};

    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            pt_t[i] = temps_all[PT_W*i +: PT_W];
            pt_p[i] = pcts_all[PT_W*i +: PT_W];
        end
        for (int i = 0; i < CURVE_POINTS; i++) begin
            hit[i] = $signed(sample_ext)
                     <= $signed(CMP_W'(pt_t[i]) << TEMP_FRACTION_BITS);
        end
    end

    // Pick the first point at or above the sample, with its predecessor.
    always_comb begin
        found  = 1'b0;
        first  = 1'b0;
        sel    = SEG_W'(CURVE_POINTS);
        cur_t  = '0;
        cur_p  = pt_p[CURVE_POINTS-1];
        prev_t = '0;
        prev_p = '0;
        for (int i = CURVE_POINTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                sel   = SEG_W'(i);
                cur_t = pt_t[i];
                cur_p = pt_p[i];
                if (i > 0) begin
                    first  = 1'b0;
                    prev_t = pt_t[i-1];
                    prev_p = pt_p[i-1];
                end else begin
                    first  = 1'b1;
                    prev_t = '0;
                    prev_p = '0;
                end
            end
        end
    end

    // Build the job: offsets and span in sample units, percentage step.
    assign num_full = sample_ext - (CMP_W'(prev_t) << TEMP_FRACTION_BITS);
    assign t_span   = cur_t - prev_t;

    always_comb begin
        o_job.seg    = sel;
        o_job.prev_p = prev_p;
        o_job.diff   = $signed({1'b0, cur_p}) - $signed({1'b0, prev_p});
        o_job.num    = num_full[DEN_W-1:0];
        o_job.den    = DEN_W'(t_span) << TEMP_FRACTION_BITS;
        o_job.interp = found && !first && (cur_p < PT_W'(PCT_MAX));
        if (found && first) begin
            o_job.pct = sat100(cur_p);
        end else begin
            // Above the last point, or a saturated point; interpolation
            // results replace this value in the back part.
            o_job.pct = sat100(cur_p);
        end
    end

endmodule

>>> rtl/fci_queue.sv
// ----------------------------------------------------------------------------
// Fan curve job queue
// Small FIFO that decouples the front end from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module fci_queue
    import fci_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_stat
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    // Storage for queued items.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/fci_back.sv
// ----------------------------------------------------------------------------
// Fan curve arithmetic pipeline
// Multiplies, sums and divides an interpolation job one quotient bit per
// stage, then saturates and forms the PWM duty in the output register.
// ----------------------------------------------------------------------------
module fci_back
    import fci_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  t_qstat             i_qstat,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [PCT_W-1:0]   o_fan_percent,
    output logic [DUTY_W-1:0]  o_pwm_duty,
    output logic [SEG_W-1:0]   o_segment
);

    typedef struct packed {
        logic                   interp;
        logic [PCT_W-1:0]       pct;
        logic [SEG_W-1:0]       seg;
        logic [DEN_W-1:0]       den;
        logic [P1_W-1:0]        p1;
        logic signed [P2_W-1:0] p2;
    } t_prod;

    typedef struct packed {
        logic             interp;
        logic [PCT_W-1:0] pct;
        logic [SEG_W-1:0] seg;
        logic [DEN_W-1:0] den;
        logic [V_W-1:0]   rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    logic               adv;
    logic               r_s0_valid;
    t_prod              r_s0;
    logic               r_s1_valid;
    t_div               r_s1;
    logic               r_dv_valid [QUO_W];
    t_div               r_dv [QUO_W];
    t_div               w_src [QUO_W];
    t_div               n_dv [QUO_W];
    logic [V_W-1:0]     w_dsh [QUO_W];
    logic signed [P2_W:0] sum;
    logic [PCT_W-1:0]   fin_pct;
    t_div               last;

    logic               r_out_valid;
    logic [PCT_W-1:0]   r_out_pct;
    logic [SEG_W-1:0]   r_out_seg;
    logic [PROD_W-1:0]  r_out_prod;

    // The whole pipeline moves while the output register can take an item.
    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_qstat.empty;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < QUO_W; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (adv) begin
            r_s0_valid    <= !i_qstat.empty;
            r_s1_valid    <= r_s0_valid;
            r_dv_valid[0] <= r_s1_valid;
            for (int k = 1; k < QUO_W; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
            r_out_valid <= r_dv_valid[QUO_W-1];
        end
    end

    // Stage 0: the two partial products of the interpolation numerator.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0.interp <= i_job.interp;
            r_s0.pct    <= i_job.pct;
            r_s0.seg    <= i_job.seg;
            r_s0.den    <= i_job.den;
            r_s0.p1     <= P1_W'(i_job.prev_p) * P1_W'(i_job.den);
            r_s0.p2     <= $signed(P2_W'({1'b0, i_job.num}))
                           * $signed({{(P2_W-DIFF_W){i_job.diff[DIFF_W-1]}}, i_job.diff});
        end
    end

    // Stage 1: numerator sum, which is never negative for a real job.
    assign sum = $signed((P2_W+1)'(r_s0.p1)) + $signed({r_s0.p2[P2_W-1], r_s0.p2});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1.interp <= r_s0.interp;
            r_s1.pct    <= r_s0.pct;
            r_s1.seg    <= r_s0.seg;
            r_s1.den    <= r_s0.den;
            r_s1.rem    <= sum[V_W-1:0];
            r_s1.quo    <= '0;
        end
    end

    // Restoring division, most significant quotient bit first.
    always_comb begin
        w_src[0] = r_s1;
        for (int k = 1; k < QUO_W; k++) begin
            w_src[k] = r_dv[k-1];
        end
        for (int k = 0; k < QUO_W; k++) begin
            w_dsh[k] = V_W'(w_src[k].den) << (QUO_W - 1 - k);
            n_dv[k]  = w_src[k];
            if (w_src[k].rem >= w_dsh[k]) begin
                n_dv[k].rem = w_src[k].rem - w_dsh[k];
                n_dv[k].quo[QUO_W-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // Output register: pick the result and scale it to a duty value.
    assign last    = r_dv[QUO_W-1];
    assign fin_pct = last.interp ? sat100(last.quo) : last.pct;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pct  <= fin_pct;
            r_out_seg  <= last.seg;
            r_out_prod <= PROD_W'(fin_pct) * PROD_W'(PWM_MUL);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fan_percent = r_out_pct;
    assign o_segment     = r_out_seg;
    assign o_pwm_duty    = r_out_prod[PWM_SHIFT +: DUTY_W];

endmodule

>>> rtl/fci_checker.sv
// ----------------------------------------------------------------------------
// Fan curve interpolator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fci_checker
    import fci_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [PCT_W-1:0]          o_fan_percent,
    input logic [DUTY_W-1:0]         o_pwm_duty,
    input logic [SEG_W-1:0]          o_segment
);

    logic [15:0] pct_x255;
    logic [15:0] duty_lo;
    logic [15:0] duty_hi;

    assign pct_x255 = 16'(o_fan_percent) * 16'd255;
    assign duty_lo  = 16'(o_pwm_duty) * 16'd100;
    assign duty_hi  = (16'(o_pwm_duty) + 16'd1) * 16'd100;

    // A result held back by the receiver stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // The percentage never leaves its range, and the segment never exceeds the count.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fan_percent <= PCT_W'(PCT_MAX))
                    && (o_segment <= SEG_W'(CURVE_POINTS)))
        else $error("result field out of range");

    // The duty is the integer quotient of percent times 255 over 100.
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (duty_lo <= pct_x255) && (pct_x255 < duty_hi))
        else $error("duty does not match percentage");

    // No result is offered in the first cycle after reset is released.
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid)
        else $error("result offered after reset");

endmodule

bind fan_curve_interpolator fci_checker u_fci_checker (.*);

>>> dv/fan_curve_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fan curve checker
// Watches the register port and both item channels of the fan curve
// interpolator. It keeps its own copy of the curve, works out the result
// of every accepted sample and compares each delivered result against the
// oldest result still owed.
// ----------------------------------------------------------------------------
module fan_curve_checker
    import fci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic signed [TEMP_W-1:0]  i_temperature,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [PCT_W-1:0]          i_fan_percent,
    input  logic [DUTY_W-1:0]         i_pwm_duty,
    input  logic [SEG_W-1:0]          i_segment,
    output int                        o_fail_count,
    output int                        o_pending
);

    // One result item as the block should deliver it.
    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [DUTY_W-1:0] duty;
        logic [SEG_W-1:0]  seg;
    } t_fan_result;

    // Local copy of the curve points.
    logic [PT_W-1:0] curve_temp [MAX_POINTS];
    logic [PT_W-1:0] curve_pct  [MAX_POINTS];

    t_fan_result expected_fan_q [$];
    int          fail_total = 0;

    // Walk the curve, pick the first point at or above the sample and
    // interpolate from the point before it with exact integer arithmetic.
    function automatic t_fan_result fan_curve_lookup(input logic signed [TEMP_W-1:0] temp);
        t_fan_result r;
        int          scale;
        int          sample;
        int          cur_t;
        int          cur_p;
        int          prev_t;
        int          prev_p;
        int          num;
        int          den;
        int          v;
        int          pct;
        int          seg;
        bit          found;
        scale  = 1 << TEMP_FRACTION_BITS;
        sample = int'(temp);
        prev_t = 0;
        prev_p = 0;
        cur_p  = 0;
        pct    = 0;
        seg    = CURVE_POINTS;
        found  = 1'b0;
        for (int i = 0; i < CURVE_POINTS; i++) begin
            if (!found) begin
                cur_t = int'(curve_temp[i]);
                cur_p = int'(curve_pct[i]);
                if (sample <= cur_t * scale) begin
                    found = 1'b1;
                    seg   = i;
                    if (cur_p >= PCT_MAX) begin
                        pct = PCT_MAX;
                    end else if (i > 0) begin
                        num = sample - prev_t * scale;
                        den = (cur_t - prev_t) * scale;
                        v   = prev_p * den + num * (cur_p - prev_p);
                        if (den <= 0 || v < 0) begin
                            pct = 0;
                        end else begin
                            pct = v / den;
                        end
                    end else begin
                        pct = cur_p;
                    end
                end else begin
                    prev_t = cur_t;
                    prev_p = cur_p;
                end
            end
        end
        // Beyond the last point the last percentage stands.
        if (!found) begin
            pct = cur_p;
        end
        if (pct > PCT_MAX) begin
            pct = PCT_MAX;
        end
        r.pct  = PCT_W'(pct);
        r.duty = DUTY_W'(pct * 255 / 100);
        r.seg  = SEG_W'(seg);
        return r;
    endfunction

    // Track register writes, queue predictions and check delivered items.
    always @(posedge i_clk) begin : monitor
        t_fan_result want;
        bit          bad;
        if (!i_rst_n) begin
            expected_fan_q.delete();
            for (int k = 0; k < MAX_POINTS; k++) begin
                curve_temp[k] = '0;
                curve_pct[k]  = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_TEMPS_LOW: begin
                        for (int k = 0; k < 5; k++) curve_temp[k] = i_cfg_data[8*k +: 8];
                    end
                    REG_TEMPS_HIGH: begin
                        for (int k = 0; k < 4; k++) curve_temp[5+k] = i_cfg_data[8*k +: 8];
                    end
                    REG_PCTS_LOW: begin
                        for (int k = 0; k < 5; k++) curve_pct[k] = i_cfg_data[8*k +: 8];
                    end
                    REG_PCTS_HIGH: begin
                        for (int k = 0; k < 4; k++) curve_pct[5+k] = i_cfg_data[8*k +: 8];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                expected_fan_q.push_back(fan_curve_lookup(i_temperature));
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_fan_q.size() == 0) begin
                    $display("%0t: result with none owed: percent %0d duty %0d segment %0d",
                             $time, i_fan_percent, i_pwm_duty, i_segment);
                    fail_total++;
                end else begin
                    want = expected_fan_q.pop_front();
                    bad  = 1'b0;
                    if (i_fan_percent !== want.pct) begin
                        $display("%0t: fan_percent expected %0d actual %0d",
                                 $time, want.pct, i_fan_percent);
                        bad = 1'b1;
                    end
                    if (i_pwm_duty !== want.duty) begin
                        $display("%0t: pwm_duty expected %0d actual %0d",
                                 $time, want.duty, i_pwm_duty);
                        bad = 1'b1;
                    end
                    if (i_segment !== want.seg) begin
                        $display("%0t: segment expected %0d actual %0d",
                                 $time, want.seg, i_segment);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= expected_fan_q.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> dv/tb_fan_curve_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fan curve interpolator testbench
// Programs a series of curves, from hand-picked ones through random and
// extreme settings, and streams temperature samples through the block with
// random idle bursts on both channels. The checker beside the block does
// the predicting and comparing; this module makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb_fan_curve_interpolator;
    import fci_pkg::*;

    localparam int FLUSH_CYCLES = 24;
    localparam int HOLD_CYCLES  = 80;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 236;

    // Shapes of the curves programmed in the random part.
    typedef enum int {
        CURVE_RISING,
        CURVE_NOISE,
        CURVE_ALL_ONES,
        CURVE_FLAT_ZERO,
        CURVE_RISING_HOT
    } t_curve_kind;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index   = '0;
    logic [CFG_W-1:0]          i_cfg_data    = '0;
    logic                      i_valid       = 1'b0;
    logic signed [TEMP_W-1:0]  i_temperature = '0;
    logic                      i_stall       = 1'b0;
    logic                      o_cfg_ready;
    logic                      o_stall;
    logic                      o_valid;
    logic [PCT_W-1:0]          o_fan_percent;
    logic [DUTY_W-1:0]         o_pwm_duty;
    logic [SEG_W-1:0]          o_segment;

    int fail_count;
    int pending;

    // Idling control shared by the two sides.
    bit idle_enable  = 1'b1;
    bit hold_request = 1'b0;

    // Curve currently being programmed.
    logic [PT_W-1:0] curve_t [MAX_POINTS];
    logic [PT_W-1:0] curve_p [MAX_POINTS];

    t_curve_kind phase_kind [NUM_PHASES] = '{CURVE_RISING, CURVE_NOISE, CURVE_ALL_ONES,
                                             CURVE_RISING, CURVE_FLAT_ZERO, CURVE_RISING_HOT,
                                             CURVE_RISING, CURVE_NOISE};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    fan_curve_interpolator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fan_percent (o_fan_percent),
        .o_pwm_duty    (o_pwm_duty),
        .o_segment     (o_segment)
    );

    fan_curve_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_temperature (i_temperature),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_fan_percent (o_fan_percent),
        .i_pwm_duty    (o_pwm_duty),
        .i_segment     (o_segment),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // One register write; valid stays high so writes can follow back to back.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write the whole curve; the high registers get junk in their unused byte.
    task automatic program_curve();
        write_reg(REG_TEMPS_LOW, {curve_t[4], curve_t[3], curve_t[2], curve_t[1], curve_t[0]});
        write_reg(REG_TEMPS_HIGH,
                  {8'($urandom), curve_t[8], curve_t[7], curve_t[6], curve_t[5]});
        write_reg(REG_PCTS_LOW, {curve_p[4], curve_p[3], curve_p[2], curve_p[1], curve_p[0]});
        write_reg(REG_PCTS_HIGH,
                  {8'($urandom), curve_p[8], curve_p[7], curve_p[6], curve_p[5]});
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one sample, after an occasional idle burst, and wait for acceptance.
    task automatic send_temp(input int t);
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_temperature <= TEMP_W'(t);
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait until every owed result has been delivered.
    task automatic finish_phase();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic randomize_curve(input t_curve_kind kind);
        int t;
        int p;
        t = $urandom_range(0, 40);
        p = $urandom_range(0, 20);
        for (int k = 0; k < MAX_POINTS; k++) begin
            case (kind)
                CURVE_RISING: begin
                    curve_t[k] = PT_W'(t);
                    curve_p[k] = PT_W'(p);
                    t = t + $urandom_range(1, 25);
                    p = (p + $urandom_range(0, 14) > PCT_MAX) ? PCT_MAX
                                                              : p + $urandom_range(0, 14);
                end
                CURVE_RISING_HOT: begin
                    curve_t[k] = PT_W'(t);
                    curve_p[k] = PT_W'($urandom_range(0, 255));
                    t = t + $urandom_range(1, 25);
                end
                CURVE_NOISE: begin
                    curve_t[k] = PT_W'($urandom_range(0, 255));
                    curve_p[k] = PT_W'($urandom_range(0, 255));
                end
                CURVE_ALL_ONES: begin
                    curve_t[k] = '1;
                    curve_p[k] = '1;
                end
                default: begin
                    curve_t[k] = '0;
                    curve_p[k] = PT_W'($urandom_range(0, 255));
                end
            endcase
        end
    endtask

    // Samples mostly fall around the curve, some near a point, some anywhere.
    function automatic int pick_temperature();
        int lo;
        int hi;
        int r;
        lo = 255;
        hi = 0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (int'(curve_t[k]) < lo) lo = int'(curve_t[k]);
            if (int'(curve_t[k]) > hi) hi = int'(curve_t[k]);
        end
        lo = lo * 16 - 40;
        hi = hi * 16 + 40;
        if (lo < -2048) lo = -2048;
        if (hi > 4095) hi = 4095;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return int'($urandom_range(0, 8191)) - 4096;
        end else if (r == 2) begin
            return int'(curve_t[$urandom_range(0, MAX_POINTS - 1)]) * 16
                   + int'($urandom_range(0, 2)) - 1;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Result side: random stall bursts and one long hold-off on request.
    initial begin : result_side
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Curve as left by reset: every point at zero degrees and zero percent.
        send_temp(-2048);
        send_temp(0);
        send_temp(1);
        send_temp(4095);
        finish_phase();

        // Rising curve whose last point is above 100 percent.
        curve_t = '{8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 8'd100};
        curve_p = '{8'd5, 8'd10, 8'd25, 8'd40, 8'd55, 8'd70, 8'd85, 8'd95, 8'd120};
        program_curve();
        send_temp(-2048);
        send_temp(320);
        send_temp(321);
        send_temp(479);
        send_temp(480);
        send_temp(1000);
        send_temp(1599);
        send_temp(1600);
        send_temp(1601);
        send_temp(4095);
        finish_phase();

        // Unordered curve with a first percentage above 100, so that
        // interpolation from it overshoots and saturates.
        curve_t = '{8'd10, 8'd50, 8'd30, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        curve_p = '{8'd150, 8'd20, 8'd60, 8'd99, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        program_curve();
        send_temp(-2048);
        send_temp(160);
        send_temp(400);
        send_temp(801);
        send_temp(4080);
        send_temp(4095);
        finish_phase();

        // Random part: one curve per phase, no idling in the last phase.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) begin
                idle_enable = 1'b0;
            end
            randomize_curve(phase_kind[ph]);
            program_curve();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 40) begin
                    hold_request = 1'b1;
                end
                send_temp(pick_temperature());
            end
            finish_phase();
        end

        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #3_200_000;
        $display("status: fail");
        $finish;
    end

endmodule
